### rtl/core/gpf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gpf_pkg;

	localparam int CFG_SIZE_W = 7;
	localparam logic [CFG_SIZE_W-1:0] CFG_SIZE_RESET = 7'd64;
	localparam int SIZE_MIN = 4;
	localparam int ROW_COL_W = 6;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic REG_GRID_SIZE = 1'b0;

	typedef struct packed {
		logic emit;
		logic done;
		logic [ROW_COL_W-1:0] row;
		logic [ROW_COL_W-1:0] col;
	} gpf_point_t;

endpackage

`default_nettype wire

### rtl/core/gpf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gpf_in_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH-1:0] potential;
	logic grid_start;

	modport source(output valid, potential, grid_start, input ready);
	modport sink(input valid, potential, grid_start, output ready);
endinterface

`default_nettype wire

### rtl/core/gpf_out_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface gpf_out_if #(
	parameter int SAMPLE_WIDTH = 16
);
	logic valid;
	logic ready;
	logic signed [SAMPLE_WIDTH:0] field_x_twice;
	logic signed [SAMPLE_WIDTH+1:0] field_y_twice;
	logic [5:0] point_row;
	logic [5:0] point_col;
	logic grid_done;

	modport source(output valid, field_x_twice, field_y_twice, point_row, point_col,
		grid_done, input ready);
	modport sink(input valid, field_x_twice, field_y_twice, point_row, point_col,
		grid_done, output ready);
endinterface

`default_nettype wire

### rtl/core/grid_potential_to_field_stencil.sv
`timescale 1ns / 1ps
`default_nettype none

// The result for point (r,c) is formed from stage 1 holding sample (r,c+1), then registered at the output.
// Throughput: one sample per cycle unless the output stalls, set by the single-port read-then-write line buffer.
// The window sample cells left0, left1 and upper_left shift once per sample leaving stage 1.
// Reset: row/column counters, window cells and valid flags clear, grid size returns to 64.
// The line buffer is not cleared; entries are valid once the first row has streamed.
module grid_potential_to_field_stencil import gpf_pkg::*; #(
	parameter int GRID_SIZE    = 64,
	parameter int SAMPLE_WIDTH = 16
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  psel,
	input  wire logic                  penable,
	input  wire logic                  pwrite,
	input  wire logic [APB_ADDR_W-1:0] paddr,
	input  wire logic [APB_DATA_W-1:0] pwdata,
	output logic      [APB_DATA_W-1:0] prdata,
	output logic                       pready,
	gpf_in_if.sink                     sample_in,
	gpf_out_if.source                  field_out
);

	localparam int W  = SAMPLE_WIDTH;
	localparam int AW = $clog2(GRID_SIZE);

	logic [CFG_SIZE_W-1:0] size_q;
	logic                  accept, adv_s1, out_free, out_load;
	logic                  v_s1;
	logic [W-1:0]          s_s1, up_s1;
	logic [AW-1:0]         col_addr;
	gpf_point_t            point_s1;
	logic [W-1:0]          left0, left1, upper_left;

	logic signed [W:0]     fx;
	logic signed [W+1:0]   fy;

	logic                  out_valid_q;
	logic signed [W:0]     field_x_q;
	logic signed [W+1:0]   field_y_q;
	logic [ROW_COL_W-1:0]  point_row_q, point_col_q;
	logic                  grid_done_q;

	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= CFG_SIZE_RESET;
		end else if (psel && penable && pwrite && pready && paddr[2] == REG_GRID_SIZE) begin
			size_q <= pwdata[CFG_SIZE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (paddr[2] == REG_GRID_SIZE) begin
			prdata = APB_DATA_W'(size_q);
		end
	end

	assign out_free        = !out_valid_q || field_out.ready;
	assign adv_s1          = v_s1 && (!point_s1.emit || out_free);
	assign sample_in.ready = !v_s1 || adv_s1;
	assign accept          = sample_in.valid && sample_in.ready;
	assign out_load        = adv_s1 && point_s1.emit;

	gpf_raster_ctl #(
		.GRID_SIZE(GRID_SIZE),
		.AW       (AW)
	) u_ctl (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.grid_start(sample_in.grid_start),
		.size_cfg  (size_q),
		.col_addr  (col_addr),
		.point_s1  (point_s1)
	);

	gpf_line_buf #(
		.W    (W),
		.DEPTH(GRID_SIZE),
		.AW   (AW)
	) u_line (
		.clk     (clk),
		.en      (accept),
		.addr    (col_addr),
		.wdata   (sample_in.potential),
		.rdata_s1(up_s1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (sample_in.ready) begin
			v_s1 <= sample_in.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			s_s1 <= sample_in.potential;
		end
	end

	gpf_tap_cell #(.W(W)) u_left0 (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (adv_s1),
		.d     (s_s1),
		.q     (left0)
	);

	gpf_tap_cell #(.W(W)) u_left1 (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (adv_s1),
		.d     (left0),
		.q     (left1)
	);

	gpf_tap_cell #(.W(W)) u_upper_left (
		.clk   (clk),
		.arst_n(arst_n),
		.shift (adv_s1),
		.d     (up_s1),
		.q     (upper_left)
	);

	always_comb begin
		fx = $signed({left1[W-1], left1}) - $signed({s_s1[W-1], s_s1});
		fy = ($signed({{2{upper_left[W-1]}}, upper_left}) + $signed({{2{up_s1[W-1]}}, up_s1}))
			- ($signed({{2{left0[W-1]}}, left0}) + $signed({{2{s_s1[W-1]}}, s_s1}));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (field_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			field_x_q   <= fx;
			field_y_q   <= fy;
			point_row_q <= point_s1.row;
			point_col_q <= point_s1.col;
			grid_done_q <= point_s1.done;
		end
	end

	assign field_out.valid         = out_valid_q;
	assign field_out.field_x_twice = field_x_q;
	assign field_out.field_y_twice = field_y_q;
	assign field_out.point_row     = point_row_q;
	assign field_out.point_col     = point_col_q;
	assign field_out.grid_done     = grid_done_q;

endmodule

`default_nettype wire

### rtl/core/gpf_tap_cell.sv
`timescale 1ns / 1ps
`default_nettype none

module gpf_tap_cell #(
	parameter int W = 16
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         shift,
	input  wire logic [W-1:0] d,
	output logic      [W-1:0] q
);

	logic [W-1:0] tap_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_q <= '0;
		end else if (shift) begin
			tap_q <= d;
		end
	end

	assign q = tap_q;

endmodule

`default_nettype wire

### rtl/core/gpf_line_buf.sv
`timescale 1ns / 1ps
`default_nettype none

module gpf_line_buf #(
	parameter int W     = 16,
	parameter int DEPTH = 64,
	parameter int AW    = $clog2(DEPTH)
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] addr,
	input  wire logic [W-1:0]  wdata,
	output logic      [W-1:0]  rdata_s1
);

	logic [W-1:0] mem [DEPTH];

	// read the previous row's sample, then overwrite it with the current one
	always_ff @(posedge clk) begin
		if (en) begin
			rdata_s1  <= mem[addr];
			mem[addr] <= wdata;
		end
	end

endmodule

`default_nettype wire

### rtl/core/gpf_raster_ctl.sv
`timescale 1ns / 1ps
`default_nettype none

module gpf_raster_ctl import gpf_pkg::*; #(
	parameter int GRID_SIZE = 64,
	parameter int AW        = $clog2(GRID_SIZE)
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  accept,
	input  wire logic                  grid_start,
	input  wire logic [CFG_SIZE_W-1:0] size_cfg,
	output logic      [AW-1:0]         col_addr,
	output gpf_point_t                 point_s1
);

	localparam int CLG = $clog2(GRID_SIZE + 1);
	localparam int SW  = (CLG > CFG_SIZE_W) ? CLG : CFG_SIZE_W;

	logic [SW-1:0] row_q, col_q;
	logic [SW-1:0] size, size_raw, size_m2, size_m3;
	logic [SW-1:0] row_a, col_a, row_n, col_n, col_m1;
	gpf_point_t    point;

	always_comb begin
		size_raw = SW'(size_cfg);
		size     = size_raw;
		if (size_raw < SW'(SIZE_MIN)) begin
			size = SW'(SIZE_MIN);
		end
		if (size_raw > SW'(GRID_SIZE)) begin
			size = SW'(GRID_SIZE);
		end
		size_m2 = size - SW'(2);
		size_m3 = size - SW'(3);

		row_a = grid_start ? '0 : row_q;
		col_a = grid_start ? '0 : col_q;
		if (col_a >= size) begin
			col_a = '0;
			row_a = row_a + SW'(1);
		end
		if (row_a >= size) begin
			row_a = '0;
		end

		col_n = col_a + SW'(1);
		row_n = row_a;
		if (col_n >= size) begin
			col_n = '0;
			row_n = row_a + SW'(1);
			if (row_n >= size) begin
				row_n = '0;
			end
		end

		col_m1     = col_a - SW'(1);
		point.emit = (row_a >= SW'(1)) && (row_a <= size_m3) &&
			(col_a >= SW'(2)) && (col_a <= size_m2);
		point.done = (row_a == size_m3) && (col_a == size_m2);
		point.row  = row_a[ROW_COL_W-1:0];
		point.col  = col_m1[ROW_COL_W-1:0];
	end

	assign col_addr = col_a[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q    <= '0;
			col_q    <= '0;
			point_s1 <= '0;
		end else if (accept) begin
			row_q    <= row_n;
			col_q    <= col_n;
			point_s1 <= point;
		end
	end

endmodule

`default_nettype wire

### rtl/core/gpf_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module gpf_checker #(
	parameter int GRID_SIZE = 64
) (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [5:0] point_row,
	input wire logic [5:0] point_col,
	input wire logic       grid_done
);

	// hold a stalled result
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_reset_idle: assert property (@(posedge clk) !arst_n |-> !out_valid)
		else $error("result shown during reset");

	a_in_open: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input blocked with empty output");

	a_done_diag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && grid_done |-> point_row == point_col)
		else $error("last point of grid off the diagonal");

	a_interior: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (GRID_SIZE > 64) || (point_row != 6'd0 && point_col != 6'd0))
		else $error("result on a border point");

endmodule

bind grid_potential_to_field_stencil gpf_checker #(
	.GRID_SIZE(GRID_SIZE)
) u_gpf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.in_ready (sample_in.ready),
	.out_valid(field_out.valid),
	.out_ready(field_out.ready),
	.point_row(field_out.point_row),
	.point_col(field_out.point_col),
	.grid_done(field_out.grid_done)
);

`default_nettype wire
